[hw/rtl/ssm_pkg.sv]
// Package for the sorted identifier set block.
// Holds field widths, default table depth, request codes and the compare result type.
// No dependencies.
package ssm_pkg;

  // Width of one identifier.
  localparam int IdW = 32;

  // Width of the reported entry count.
  localparam int CountOutW = 7;

  // Default table depth.
  localparam int MaxEntriesDef = 64;

  // Request function codes.
  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  // Result of the shared magnitude comparator: operand a against operand b.
  typedef struct packed {
    logic gt;
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

[hw/rtl/ssm_if.sv]
// Request and response channel interfaces of the sorted identifier set block.
// Depends on ssm_pkg for the field widths.

// Request channel: one load or one membership query per request.
interface ssm_req_if;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [ssm_pkg::IdW-1:0]  value;
  logic                     last;

  modport source (output valid, output func, output value, output last, input ready);
  modport sink   (input valid, input func, input value, input last, output ready);
endinterface

// Response channel: one result per request.
interface ssm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          member;
  logic                          overflow;
  logic [ssm_pkg::CountOutW-1:0] stored_count;

  modport source (output valid, output member, output overflow, output stored_count,
                  input ready);
  modport sink   (input valid, input member, input overflow, input stored_count,
                  output ready);
endinterface

[hw/rtl/sorted_id_set_membership.sv]
// A load answers in the cycle after acceptance; so does a query on the primary identifier.
// Other queries make at most ceil(log2(count+1)) probes, each a table read and a compare.
// A load marked last runs the Shell sort before it answers; each shift is one more compare.
// One request at a time; the single read port of the table sets the sort and search time.
// Reset clears the entry count and the primary identifier; the table is not cleared.
module sorted_id_set_membership #(
  parameter int MaxEntries = ssm_pkg::MaxEntriesDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  ssm_req_if.sink                 req_i,
  ssm_rsp_if.source               rsp_o,
  input  logic                    cfg_we_i,
  input  logic [ssm_pkg::IdW-1:0] cfg_wdata_i
);

  localparam int IdxW      = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW      = $clog2(MaxEntries + 1);
  localparam int CountOutW = ssm_pkg::CountOutW;

  logic [ssm_pkg::IdW-1:0] primary_id_q;
  logic                    primary_hit;
  logic                    mem_we;
  logic [IdxW-1:0]         mem_waddr;
  logic [ssm_pkg::IdW-1:0] mem_wdata;
  logic                    mem_re;
  logic [IdxW-1:0]         mem_raddr;
  logic [ssm_pkg::IdW-1:0] mem_rdata;
  logic [ssm_pkg::IdW-1:0] cmp_b;
  ssm_pkg::cmp_res_t       cmp_res;
  logic [CntW-1:0]         count;

  // Primary identifier register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primary_id_q <= '0;
    end else if (cfg_we_i) begin
      primary_id_q <= cfg_wdata_i;
    end
  end

  assign primary_hit = (req_i.value == primary_id_q);

  // Identifier table.
  ssm_mem #(
    .Depth (MaxEntries),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared comparator on the table read data.
  ssm_cmp u_cmp (
    .a_i   (mem_rdata),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  // Sequencer.
  ssm_ctrl #(
    .MaxEntries (MaxEntries),
    .IdxW       (IdxW),
    .CntW       (CntW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_i.valid),
    .req_ready_o    (req_i.ready),
    .req_func_i     (req_i.func),
    .req_value_i    (req_i.value),
    .req_last_i     (req_i.last),
    .primary_hit_i  (primary_hit),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_member_o   (rsp_o.member),
    .rsp_overflow_o (rsp_o.overflow),
    .rsp_count_o    (count),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .cmp_b_o        (cmp_b),
    .cmp_res_i      (cmp_res)
  );

  // Reported count is the entry count folded to the field width.
  assign rsp_o.stored_count = CountOutW'(count);

endmodule

[hw/rtl/ssm_mem.sv]
// Identifier table: one write port and one registered read port.
// Depends on ssm_pkg for the identifier width. Contents are undefined after reset.
module ssm_mem #(
  parameter int Depth = ssm_pkg::MaxEntriesDef,
  parameter int AddrW = 6
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic [ssm_pkg::IdW-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [AddrW-1:0]        raddr_i,
  output logic [ssm_pkg::IdW-1:0] rdata_o
);

  logic [ssm_pkg::IdW-1:0] mem [Depth];
  logic [ssm_pkg::IdW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/ssm_cmp.sv]
// Shared unsigned magnitude comparator used by both the sort and the search.
// Depends on ssm_pkg for the identifier width and the result struct.
module ssm_cmp (
  input  logic [ssm_pkg::IdW-1:0] a_i,
  input  logic [ssm_pkg::IdW-1:0] b_i,
  output ssm_pkg::cmp_res_t       res_o
);

  // One compare, three views of it.
  always_comb begin
    res_o.gt = (a_i > b_i);
    res_o.lt = (a_i < b_i);
    res_o.eq = (a_i == b_i);
  end

endmodule

[hw/rtl/ssm_ctrl.sv]
// Sequencer of the sorted identifier set block: loads, Shell sort passes and binary search.
// Depends on ssm_pkg; drives the table ports and the shared comparator operand.
module ssm_ctrl #(
  parameter int MaxEntries = ssm_pkg::MaxEntriesDef,
  parameter int IdxW       = 6,
  parameter int CntW       = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Request side.
  input  logic                    req_valid_i,
  output logic                    req_ready_o,
  input  logic                    req_func_i,
  input  logic [ssm_pkg::IdW-1:0] req_value_i,
  input  logic                    req_last_i,
  input  logic                    primary_hit_i,
  // Response side.
  output logic                    rsp_valid_o,
  input  logic                    rsp_ready_i,
  output logic                    rsp_member_o,
  output logic                    rsp_overflow_o,
  output logic [CntW-1:0]         rsp_count_o,
  // Table ports.
  output logic                    mem_we_o,
  output logic [IdxW-1:0]         mem_waddr_o,
  output logic [ssm_pkg::IdW-1:0] mem_wdata_o,
  output logic                    mem_re_o,
  output logic [IdxW-1:0]         mem_raddr_o,
  input  logic [ssm_pkg::IdW-1:0] mem_rdata_i,
  // Shared comparator: a is the table read data, b comes from here.
  output logic [ssm_pkg::IdW-1:0] cmp_b_o,
  input  ssm_pkg::cmp_res_t       cmp_res_i
);

  // Gap register must hold the first 3h+1 sequence value not below the count.
  localparam int GapW = CntW + 2;
  // Inverse of 3 modulo 2^GapW: an exact division of a multiple of 3 is one multiply.
  localparam int unsigned GapMod  = 1 << GapW;
  localparam int unsigned Inv3Int = ((GapMod % 3) == 2) ? (GapMod + 1) / 3
                                                        : (2 * GapMod + 1) / 3;
  localparam logic [GapW-1:0] Inv3 = GapW'(Inv3Int);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_GUP    = 10'b00_0000_0010,
    S_GAP    = 10'b00_0000_0100,
    S_ROW    = 10'b00_0000_1000,
    S_HELD   = 10'b00_0001_0000,
    S_CMP    = 10'b00_0010_0000,
    S_PUT    = 10'b00_0100_0000,
    S_SPROBE = 10'b00_1000_0000,
    S_SCMP   = 10'b01_0000_0000,
    S_RESP   = 10'b10_0000_0000
  } state_e;

  state_e                  state_q, state_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [GapW-1:0]         gap_q, gap_d;
  logic [GapW-1:0]         prev_q, prev_d;
  logic [CntW-1:0]         i_q, i_d;
  logic [IdxW-1:0]         j_q, j_d;
  logic [IdxW-1:0]         pos_q, pos_d;
  logic [ssm_pkg::IdW-1:0] held_q, held_d;
  logic [ssm_pkg::IdW-1:0] key_q, key_d;
  logic [CntW-1:0]         lo_q, lo_d;
  logic [CntW-1:0]         hi_q, hi_d;
  logic [IdxW-1:0]         mid_q, mid_d;
  logic                    member_q, member_d;
  logic                    ovf_q, ovf_d;

  logic                    req_acc;
  logic [GapW-1:0]         row_pos;
  logic [GapW-1:0]         j_step;
  logic [GapW-1:0]         gap_down;
  logic [CntW-1:0]         mid_calc;

  assign req_ready_o = (state_q == S_IDLE);
  assign req_acc     = req_valid_i && req_ready_o;

  // Index arithmetic for the insertion passes and the search midpoint.
  assign row_pos  = GapW'(i_q) + gap_q;
  assign j_step   = GapW'(j_q) - gap_q;
  assign gap_down = GapW'((gap_q - GapW'(1)) * Inv3);
  assign mid_calc = lo_q + ((hi_q - lo_q) >> 1);

  // Next-state and datapath control.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    gap_d       = gap_q;
    prev_d      = prev_q;
    i_d         = i_q;
    j_d         = j_q;
    pos_d       = pos_q;
    held_d      = held_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    member_d    = member_q;
    ovf_d       = ovf_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q;
    mem_wdata_o = held_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = j_q;
    cmp_b_o     = held_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          if (req_func_i == ssm_pkg::FuncLoad) begin
            member_d = 1'b0;
            if (cnt_q < CntW'(MaxEntries)) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = IdxW'(cnt_q);
              mem_wdata_o = req_value_i;
              cnt_d       = cnt_q + CntW'(1);
              ovf_d       = 1'b0;
            end else begin
              ovf_d = 1'b1;
            end
            if (req_last_i) begin
              gap_d   = GapW'(1);
              prev_d  = '0;
              state_d = S_GUP;
            end else begin
              state_d = S_RESP;
            end
          end else begin
            ovf_d = 1'b0;
            key_d = req_value_i;
            if (primary_hit_i) begin
              member_d = 1'b1;
              state_d  = S_RESP;
            end else begin
              member_d = 1'b0;
              lo_d     = '0;
              hi_d     = cnt_q;
              state_d  = S_SPROBE;
            end
          end
        end
      end

      // Climb the 3h+1 sequence; the last value below the count starts the sort.
      S_GUP: begin
        if (gap_q < GapW'(cnt_q)) begin
          prev_d = gap_q;
          gap_d  = GapW'(gap_q * GapW'(3) + GapW'(1));
        end else begin
          gap_d   = prev_q;
          state_d = S_GAP;
        end
      end

      S_GAP: begin
        if (gap_q == '0) begin
          state_d = S_RESP;
        end else begin
          i_d     = '0;
          state_d = S_ROW;
        end
      end

      // Start one insertion: fetch the element at i + gap.
      S_ROW: begin
        if (row_pos < GapW'(cnt_q)) begin
          pos_d       = IdxW'(row_pos);
          j_d         = IdxW'(i_q);
          mem_re_o    = 1'b1;
          mem_raddr_o = IdxW'(row_pos);
          state_d     = S_HELD;
        end else begin
          gap_d   = gap_down;
          state_d = S_GAP;
        end
      end

      S_HELD: begin
        held_d      = mem_rdata_i;
        mem_re_o    = 1'b1;
        mem_raddr_o = j_q;
        state_d     = S_CMP;
      end

      // Shift larger elements up by one gap while they exceed the held value.
      S_CMP: begin
        cmp_b_o = held_q;
        if (cmp_res_i.gt) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pos_q;
          mem_wdata_o = mem_rdata_i;
          pos_d       = j_q;
          if (GapW'(j_q) < gap_q) begin
            state_d = S_PUT;
          end else begin
            j_d         = IdxW'(j_step);
            mem_re_o    = 1'b1;
            mem_raddr_o = IdxW'(j_step);
          end
        end else begin
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = held_q;
        i_d         = i_q + CntW'(1);
        state_d     = S_ROW;
      end

      // Binary search over the half-open range [lo, hi).
      S_SPROBE: begin
        if (lo_q < hi_q) begin
          mid_d       = IdxW'(mid_calc);
          mem_re_o    = 1'b1;
          mem_raddr_o = IdxW'(mid_calc);
          state_d     = S_SCMP;
        end else begin
          state_d = S_RESP;
        end
      end

      S_SCMP: begin
        cmp_b_o = key_q;
        if (cmp_res_i.lt) begin
          lo_d    = CntW'(mid_q) + CntW'(1);
          state_d = S_SPROBE;
        end else if (cmp_res_i.gt) begin
          hi_d    = CntW'(mid_q);
          state_d = S_SPROBE;
        end else begin
          member_d = 1'b1;
          state_d  = S_RESP;
        end
      end

      S_RESP: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Working registers of the sort, the search and the result.
  always_ff @(posedge clk_i) begin
    gap_q    <= gap_d;
    prev_q   <= prev_d;
    i_q      <= i_d;
    j_q      <= j_d;
    pos_q    <= pos_d;
    held_q   <= held_d;
    key_q    <= key_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    member_q <= member_d;
    ovf_q    <= ovf_d;
  end

  assign rsp_valid_o    = (state_q == S_RESP);
  assign rsp_member_o   = member_q;
  assign rsp_overflow_o = ovf_q;
  assign rsp_count_o    = cnt_q;

`ifndef ASSERT_OFF
  // The entry count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(MaxEntries))
    else $error("entry count above table depth");

  // The block never takes a request while a result is still pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_ready_o |-> !rsp_valid_o)
    else $error("request taken while a result is pending");

  // During an insertion the hole sits exactly one gap above the compared element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (GapW'(pos_q) == GapW'(j_q) + gap_q))
    else $error("insertion hole not one gap above compare index");

  // A query for the primary identifier answers member without a table search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (req_func_i == ssm_pkg::FuncQuery) && primary_hit_i)
      |=> (rsp_valid_o && rsp_member_o))
    else $error("primary identifier query did not report member");
`endif

endmodule

[tb/tb_sorted_id_set_membership.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sorted_id_set_membership: directed and random load/query traffic.
// Depends on ssm_pkg, the ssm_req_if/ssm_rsp_if interfaces and the block's RTL.
module tb_sorted_id_set_membership;

  localparam int   IdW           = ssm_pkg::IdW;
  localparam int   CountOutW     = ssm_pkg::CountOutW;
  localparam int   MaxEntriesDef = ssm_pkg::MaxEntriesDef;
  localparam logic FuncLoad      = ssm_pkg::FuncLoad;
  localparam logic FuncQuery     = ssm_pkg::FuncQuery;

  localparam int RandomItems = 530;
  localparam int IdlePause   = 50;
  localparam int StallLimit  = 20000;
  localparam int ReportLimit = 200;

  // One result of the block, field by field.
  typedef struct packed {
    logic                 member;
    logic                 overflow;
    logic [CountOutW-1:0] stored_count;
  } set_answer_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [IdW-1:0]        cfg_wdata_i;

  ssm_req_if req_if ();
  ssm_rsp_if rsp_if ();

  sorted_id_set_membership u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Own copy of the identifier set: table, count and primary identifier.
  logic [IdW-1:0] id_tbl [MaxEntriesDef];
  int unsigned    id_count;
  logic [IdW-1:0] primary_id_m;

  set_answer_t    set_answers [$];
  int unsigned    error_count = 0;
  int unsigned    stall_cycles = 0;
  bit             no_idle;

  int unsigned    loads_sent;
  int unsigned    loads_dropped = 0;
  int unsigned    queries_sent;
  int unsigned    members_found = 0;
  int unsigned    primary_writes;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Shell sort of the stored entries, gap sequence 1, 4, 13, 40 and so on.
  function automatic void sort_id_table();
    int unsigned    gap;
    int unsigned    i;
    int unsigned    pos;
    int unsigned    j;
    logic [IdW-1:0] held;
    gap = 1;
    while (gap < id_count) gap = 3 * gap + 1;
    gap = gap / 3;
    while (gap != 0) begin
      for (i = 0; i + gap < id_count; i++) begin
        pos  = i + gap;
        j    = i;
        held = id_tbl[pos];
        while (id_tbl[j] > held) begin
          id_tbl[pos] = id_tbl[j];
          pos = j;
          if (j < gap) break;
          j -= gap;
        end
        id_tbl[pos] = held;
      end
      gap = gap / 3;
    end
  endfunction

  // Binary search over the table as it stands, sorted or not.
  function automatic bit find_id(input logic [IdW-1:0] key);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = id_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (key > id_tbl[mid]) begin
        lo = mid + 1;
      end else if (key < id_tbl[mid]) begin
        hi = mid;
      end else begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one accepted request to the set and returns the answer it must produce.
  function automatic set_answer_t apply_request(input logic func, input logic [IdW-1:0] value,
                                                input logic is_last);
    set_answer_t ans;
    ans = '0;
    if (func == FuncLoad) begin
      if (id_count < MaxEntriesDef) begin
        id_tbl[id_count] = value;
        id_count++;
      end else begin
        ans.overflow = 1'b1;
      end
      if (is_last) sort_id_table();
    end else begin
      ans.member = (value == primary_id_m) || find_id(value);
    end
    ans.stored_count = CountOutW'(id_count);
    return ans;
  endfunction

  // Identifiers with a bias toward extremes and small values, so duplicates occur.
  function automatic logic [IdW-1:0] random_id();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return IdW'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  // Query keys: stored values, their neighbors, the primary identifier, or anything.
  function automatic logic [IdW-1:0] query_key();
    int unsigned    pick;
    logic [IdW-1:0] base;
    pick = $urandom_range(99);
    base = (id_count != 0) ? id_tbl[$urandom_range(id_count - 1)] : random_id();
    if (pick < 40) return base;
    if (pick < 55) return $urandom_range(1) ? base + 32'd1 : base - 32'd1;
    if (pick < 70) return primary_id_m;
    return random_id();
  endfunction

  // Sends one request, with random gaps, and records its answer on acceptance.
  task automatic send_request(input logic func, input logic [IdW-1:0] value,
                              input logic is_last);
    while (!no_idle && $urandom_range(99) < 23) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func  <= func;
    req_if.value <= value;
    req_if.last  <= is_last;
    do @(posedge clk_i); while (!req_if.ready);
    set_answers.push_back(apply_request(func, value, is_last));
    if (func == FuncLoad) loads_sent++;
    else queries_sent++;
  endtask

  // Stops sending and waits until every answer is back and the block has settled.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (set_answers.size() != 0) @(posedge clk_i);
    repeat (IdlePause) @(posedge clk_i);
  endtask

  task automatic write_primary_id(input logic [IdW-1:0] id);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= id;
    @(posedge clk_i);
    primary_id_m = id;
    primary_writes++;
    cfg_we_i <= 1'b0;
  endtask

  // Queries on an empty table: only the primary identifier (zero after reset) is a member.
  task automatic test_empty_table();
    send_request(FuncQuery, '0, 1'b0);
    send_request(FuncQuery, '1, 1'b1);
  endtask

  // The all-ones primary identifier counts as a member, the old one no longer does.
  task automatic test_primary_id();
    write_primary_id('1);
    send_request(FuncQuery, '1, 1'b0);
    send_request(FuncQuery, '0, 1'b0);
  endtask

  // Loads with extremes and duplicates, sorted by the last one, then hits and misses.
  task automatic test_load_and_sort();
    send_request(FuncLoad, 32'h8000_0000, 1'b0);
    send_request(FuncLoad, '1, 1'b0);
    send_request(FuncLoad, '0, 1'b0);
    send_request(FuncLoad, 32'd5, 1'b0);
    send_request(FuncLoad, 32'd5, 1'b0);
    send_request(FuncLoad, 32'd1, 1'b1);
    send_request(FuncQuery, '0, 1'b0);
    send_request(FuncQuery, 32'd5, 1'b0);
    send_request(FuncQuery, 32'd4, 1'b0);
    send_request(FuncQuery, 32'h8000_0000, 1'b0);
    send_request(FuncQuery, 32'h7FFF_FFFF, 1'b0);
  endtask

  // Loads appended after a sort are searched unsorted until the next last load.
  task automatic test_query_unsorted();
    send_request(FuncLoad, 32'd3, 1'b0);
    send_request(FuncLoad, 32'd2, 1'b0);
    send_request(FuncQuery, 32'd2, 1'b0);
    send_request(FuncQuery, 32'd3, 1'b0);
    send_request(FuncLoad, 32'd7, 1'b1);
    send_request(FuncQuery, 32'd2, 1'b0);
  endtask

  // Bursts of loads, most closed by a last load, mixed with queries, over RandomItems requests.
  task automatic test_random_traffic();
    int unsigned    sent;
    int unsigned    burst;
    int unsigned    k;
    int unsigned    setting;
    logic [IdW-1:0] id;
    sent    = 0;
    setting = 0;
    while (sent < RandomItems) begin
      no_idle = (sent >= 200 && sent < 300);
      if (sent >= (setting + 1) * 110) begin
        case (setting % 4)
          0:       id = $urandom;
          1:       id = query_key();
          2:       id = '1;
          default: id = '0;
        endcase
        write_primary_id(id);
        setting++;
      end
      if ($urandom_range(99) < ((id_count < MaxEntriesDef) ? 15 : 6)) begin
        burst = $urandom_range(1, 4);
        for (k = 0; k < burst; k++) begin
          send_request(FuncLoad, random_id(), (k == burst - 1) && ($urandom_range(7) != 0));
        end
        sent += burst;
      end else begin
        send_request(FuncQuery, query_key(), 1'($urandom_range(1)));
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // Result checker: each accepted answer against the oldest one outstanding.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (set_answers.size() == 0) begin
        error_count++;
        if (error_count <= ReportLimit) begin
          $display("%0t: answer with none outstanding: member %0b overflow %0b count %0d",
                   $time, rsp_if.member, rsp_if.overflow, rsp_if.stored_count);
        end
      end else begin
        set_answer_t ans;
        ans = set_answers.pop_front();
        if (rsp_if.member === ans.member && ans.member) members_found++;
        if (rsp_if.overflow === ans.overflow && ans.overflow) loads_dropped++;
        if (rsp_if.member !== ans.member) begin
          error_count++;
          if (error_count <= ReportLimit) begin
            $display("%0t: member mismatch: expected %0b, actual %0b",
                     $time, ans.member, rsp_if.member);
          end
        end
        if (rsp_if.overflow !== ans.overflow) begin
          error_count++;
          if (error_count <= ReportLimit) begin
            $display("%0t: overflow mismatch: expected %0b, actual %0b",
                     $time, ans.overflow, rsp_if.overflow);
          end
        end
        if (rsp_if.stored_count !== ans.stored_count) begin
          error_count++;
          if (error_count <= ReportLimit) begin
            $display("%0t: stored_count mismatch: expected %0d, actual %0d",
                     $time, ans.stored_count, rsp_if.stored_count);
          end
        end
      end
    end
  end

  // Response backpressure.
  always @(posedge clk_i) begin
    rsp_if.ready <= no_idle || ($urandom_range(99) >= 23);
  end

  // Watchdog on cycles with no request or answer accepted.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, StallLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    req_if.valid   <= 1'b0;
    req_if.func    <= FuncLoad;
    req_if.value   <= '0;
    req_if.last    <= 1'b0;
    no_idle        = 1'b0;
    id_count       = 0;
    primary_id_m   = '0;
    loads_sent     = 0;
    queries_sent   = 0;
    primary_writes = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_primary_id();
    test_load_and_sort();
    test_query_unsorted();
    test_random_traffic();
    wait_idle();

    $display("Run covered %0d loads (%0d dropped on a full table) and %0d queries (%0d members).",
             loads_sent, loads_dropped, queries_sent, members_found);
    $display("Primary identifier set %0d times; table ended with %0d entries.",
             primary_writes, id_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
